### rtl/bafl_pkg.sv
// Package for the byte ALU with decimal-mode flags.
// Holds the action codes, the status bit positions and the beat types.
// Used by bafl_alu and byte_alu_with_bcd_flags_top; depends on nothing.
`default_nettype none

package bafl_pkg;

  localparam logic [4:0] ACT_ADC = 5'd0;
  localparam logic [4:0] ACT_SBC = 5'd1;
  localparam logic [4:0] ACT_AND = 5'd2;
  localparam logic [4:0] ACT_ORA = 5'd3;
  localparam logic [4:0] ACT_EOR = 5'd4;
  localparam logic [4:0] ACT_BIT = 5'd5;
  localparam logic [4:0] ACT_CMP = 5'd6;
  localparam logic [4:0] ACT_INC = 5'd7;
  localparam logic [4:0] ACT_DEC = 5'd8;
  localparam logic [4:0] ACT_LOAD = 5'd9;
  localparam logic [4:0] ACT_ASL = 5'd10;
  localparam logic [4:0] ACT_LSR = 5'd11;
  localparam logic [4:0] ACT_ROL = 5'd12;
  localparam logic [4:0] ACT_ROR = 5'd13;
  localparam logic [4:0] ACT_CLC = 5'd14;
  localparam logic [4:0] ACT_SEC = 5'd15;
  localparam logic [4:0] ACT_CLI = 5'd16;
  localparam logic [4:0] ACT_SEI = 5'd17;
  localparam logic [4:0] ACT_CLV = 5'd18;
  localparam logic [4:0] ACT_CLD = 5'd19;
  localparam logic [4:0] ACT_SED = 5'd20;

  localparam int unsigned FLAG_N = 7;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [4:0] action;
    logic [7:0] reg_value;
    logic [7:0] operand;
    logic [7:0] status_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       result_write;
    logic [7:0] status_out;
  } alu_out_t;

endpackage

`default_nettype wire

### rtl/bafl_alu.sv
// Combinational byte ALU: binary and decimal add and subtract, logic ops,
// compare, bit test, increment, decrement, shifts, rotates and flag actions.
// Depends on bafl_pkg.
`default_nettype none

module bafl_alu (
  input  wire bafl_pkg::alu_in_t alu_in,
  output bafl_pkg::alu_out_t     alu_out
);
  import bafl_pkg::*;

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] st;
  logic       c;
  logic       borrow;

  logic [8:0] sum9;
  logic [5:0] add_lo;
  logic [5:0] add_lo_adj;
  logic [9:0] add_hi;
  logic [9:0] add_hi_adj;

  logic [8:0] sub9;
  logic [5:0] sub_lo;
  logic [5:0] sub_lo_m6;
  logic [5:0] sub_lo_adj;
  logic [9:0] sub_hi;
  logic [9:0] sub_hi_adj;

  logic [8:0] cmp9;

  function automatic logic [7:0] with_nz(input logic [7:0] s, input logic [7:0] v);
    logic [7:0] r;
    r = s;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

  assign a = alu_in.reg_value;
  assign b = alu_in.operand;
  assign st = alu_in.status_in;
  assign c = st[FLAG_C];
  assign borrow = ~c;

  // Add path, with decimal nibble correction.
  assign sum9 = {1'b0, a} + {1'b0, b} + {8'b0, c};
  assign add_lo = {2'b00, a[3:0]} + {2'b00, b[3:0]} + {5'b0, c};
  assign add_lo_adj = (add_lo > 6'd9) ? add_lo + 6'h06 : add_lo;
  assign add_hi = {2'b00, a[7:4], 4'b0000} + {2'b00, b[7:4], 4'b0000}
                + ((add_lo_adj > 6'd15) ? 10'h010 : 10'h000);
  assign add_hi_adj = (add_hi > 10'h090) ? add_hi + 10'h060 : add_hi;

  // Subtract path; the nibble values are two's complement.
  assign sub9 = {1'b0, a} - {1'b0, b} - {8'b0, borrow};
  assign sub_lo = {2'b00, a[3:0]} - {2'b00, b[3:0]} - {5'b0, borrow};
  assign sub_lo_m6 = sub_lo - 6'h06;
  assign sub_lo_adj = sub_lo[5] ? {2'b11, sub_lo_m6[3:0]} : sub_lo;
  assign sub_hi = {2'b00, a[7:4], 4'b0000} - {2'b00, b[7:4], 4'b0000}
                + {{4{sub_lo_adj[5]}}, sub_lo_adj};
  assign sub_hi_adj = sub_hi[9] ? sub_hi - 10'h060 : sub_hi;

  assign cmp9 = {1'b0, a} - {1'b0, b};

  always_comb begin
    logic [7:0] res;
    logic       wr;
    logic [7:0] s;
    res = a;
    wr = 1'b1;
    s = st;
    case (alu_in.action)
      ACT_ADC: begin
        s[FLAG_V] = ~(a[7] ^ b[7]) & (b[7] ^ sum9[7]);
        if (st[FLAG_D]) begin
          res = {add_hi_adj[7:4], add_lo_adj[3:0]};
          s[FLAG_C] = (add_hi_adj > 10'h0FF);
        end else begin
          res = sum9[7:0];
          s[FLAG_C] = sum9[8];
        end
        s = with_nz(s, res);
      end
      ACT_SBC: begin
        s[FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ sub9[7]);
        res = st[FLAG_D] ? sub_hi_adj[7:0] : sub9[7:0];
        s[FLAG_C] = ~sub9[8];
        s = with_nz(s, res);
      end
      ACT_AND: begin
        res = a & b;
        s = with_nz(s, res);
      end
      ACT_ORA: begin
        res = a | b;
        s = with_nz(s, res);
      end
      ACT_EOR: begin
        res = a ^ b;
        s = with_nz(s, res);
      end
      ACT_BIT: begin
        wr = 1'b0;
        s[FLAG_Z] = ((a & b) == 8'h00);
        s[FLAG_V] = b[6];
        s[FLAG_N] = b[7];
      end
      ACT_CMP: begin
        wr = 1'b0;
        s[FLAG_C] = ~cmp9[8];
        s[FLAG_Z] = (a == b);
        s[FLAG_N] = cmp9[7];
      end
      ACT_INC: begin
        res = a + 8'd1;
        s = with_nz(s, res);
      end
      ACT_DEC: begin
        res = a - 8'd1;
        s = with_nz(s, res);
      end
      ACT_LOAD: begin
        res = b;
        s = with_nz(s, res);
      end
      ACT_ASL: begin
        res = {a[6:0], 1'b0};
        s[FLAG_C] = a[7];
        s = with_nz(s, res);
      end
      ACT_ROL: begin
        res = {a[6:0], c};
        s[FLAG_C] = a[7];
        s = with_nz(s, res);
      end
      ACT_LSR: begin
        res = {1'b0, a[7:1]};
        s[FLAG_C] = a[0];
        s = with_nz(s, res);
      end
      ACT_ROR: begin
        res = {c, a[7:1]};
        s[FLAG_C] = a[0];
        s = with_nz(s, res);
      end
      ACT_CLC: begin
        wr = 1'b0;
        s[FLAG_C] = 1'b0;
      end
      ACT_SEC: begin
        wr = 1'b0;
        s[FLAG_C] = 1'b1;
      end
      ACT_CLI: begin
        wr = 1'b0;
        s[FLAG_I] = 1'b0;
      end
      ACT_SEI: begin
        wr = 1'b0;
        s[FLAG_I] = 1'b1;
      end
      ACT_CLV: begin
        wr = 1'b0;
        s[FLAG_V] = 1'b0;
      end
      ACT_CLD: begin
        wr = 1'b0;
        s[FLAG_D] = 1'b0;
      end
      ACT_SED: begin
        wr = 1'b0;
        s[FLAG_D] = 1'b1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    alu_out.result = res;
    alu_out.result_write = wr;
    alu_out.status_out = s;
  end

endmodule

`default_nettype wire

### rtl/byte_alu_with_bcd_flags_top.sv
// Top level of the byte ALU with decimal-mode flags: input register,
// combinational ALU and result register. Depends on bafl_pkg and bafl_alu.
//
// Usage:
// The input channel carries one beat per operation: action, reg_value,
// operand and status_in. A beat is taken at a rising edge where in_valid is
// high and in_stall is low. The output channel returns one beat per input
// beat, in order: result, result_write and status_out, taken at an edge where
// out_valid is high and out_stall is low.
// A beat taken at one edge sits in the input register, passes the ALU and
// is loaded into the result register, which presents it on the output.
// Throughput is one beat per cycle while out_stall stays low. The limit is
// the single add, decimal correct and flag path between the two registers.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; in_stall rises only when both are
// full. Synchronous reset empties both registers; no beat is pending after.
`default_nettype none

module byte_alu_with_bcd_flags_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] action,
  input  wire logic [7:0] reg_value,
  input  wire logic [7:0] operand,
  input  wire logic [7:0] status_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      result,
  output logic            result_write,
  output logic [7:0]      status_out
);
  import bafl_pkg::*;

  logic     s1_valid;
  alu_in_t  s1_item;
  alu_out_t alu_res;
  logic     s2_load;
  logic     in_take;

  assign s2_load = ~out_valid | ~out_stall;
  assign in_stall = s1_valid & ~s2_load;
  assign in_take = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take | (s1_valid & ~s2_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.action <= action;
      s1_item.reg_value <= reg_value;
      s1_item.operand <= operand;
      s1_item.status_in <= status_in;
    end
  end

  bafl_alu u_alu (
    .alu_in  (s1_item),
    .alu_out (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      result <= alu_res.result;
      result_write <= alu_res.result_write;
      status_out <= alu_res.status_out;
    end
  end

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while a register is free");

  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid && $stable(s1_item))
    else $error("blocked input register lost its beat");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_load |=> out_valid)
    else $error("advanced beat missing at the output");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for byte_alu_with_bcd_flags_top: directed and random beats through the ALU,
// with each result checked against an in-file model of the decimal-mode flag rules.
// Depends on bafl_pkg and the RTL of the top level only.
`timescale 1ns / 100ps

module tb;
  import bafl_pkg::*;

  localparam int RANDOM_BEATS = 750;
  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_CAP = 100;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [4:0] action;
  logic [7:0] reg_value;
  logic [7:0] operand;
  logic [7:0] status_in;
  logic out_valid;
  logic out_stall;
  logic [7:0] result;
  logic result_write;
  logic [7:0] status_out;

  alu_out_t alu_results_due[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit sender_gaps = 1'b1;

  byte_alu_with_bcd_flags_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .reg_value(reg_value),
    .operand(operand),
    .status_in(status_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result(result),
    .result_write(result_write),
    .status_out(status_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic alu_out_t nmos_alu_result(alu_in_t beat);
    alu_out_t r;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] st;
    logic [7:0] cmp_diff;
    logic c;
    logic sets_nz;
    int sum;
    int diff;
    int lo;
    int hi;
    a = beat.reg_value;
    b = beat.operand;
    st = beat.status_in;
    c = st[FLAG_C];
    r.result = a;
    r.result_write = 1'b1;
    sets_nz = 1'b1;
    case (beat.action)
      ACT_ADC: begin
        sum = int'(a) + int'(b) + int'(c);
        st[FLAG_V] = ~(a[7] ^ b[7]) & (b[7] ^ sum[7]);
        if (st[FLAG_D]) begin
          lo = int'(a[3:0]) + int'(b[3:0]) + int'(c);
          if (lo > 9) lo = lo + 6;
          hi = int'({a[7:4], 4'h0}) + int'({b[7:4], 4'h0}) + ((lo > 15) ? 16 : 0);
          if (hi > 144) hi = hi + 96;
          r.result = {hi[7:4], lo[3:0]};
          st[FLAG_C] = (hi > 255);
        end else begin
          r.result = sum[7:0];
          st[FLAG_C] = (sum > 255);
        end
      end
      ACT_SBC: begin
        diff = int'(a) - int'(b) - (c ? 0 : 1);
        st[FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ diff[7]);
        if (st[FLAG_D]) begin
          lo = int'(a[3:0]) - int'(b[3:0]) - (c ? 0 : 1);
          if (lo < 0) lo = ((lo - 6) & 15) - 16;
          hi = int'({a[7:4], 4'h0}) - int'({b[7:4], 4'h0}) + lo;
          if (hi < 0) hi = hi - 96;
          r.result = hi[7:0];
        end else begin
          r.result = diff[7:0];
        end
        st[FLAG_C] = (diff >= 0);
      end
      ACT_AND: r.result = a & b;
      ACT_ORA: r.result = a | b;
      ACT_EOR: r.result = a ^ b;
      ACT_BIT: begin
        r.result_write = 1'b0;
        sets_nz = 1'b0;
        st[FLAG_Z] = ((a & b) == 8'h00);
        st[FLAG_V] = b[6];
        st[FLAG_N] = b[7];
      end
      ACT_CMP: begin
        cmp_diff = a - b;
        r.result_write = 1'b0;
        sets_nz = 1'b0;
        st[FLAG_C] = (a >= b);
        st[FLAG_Z] = (a == b);
        st[FLAG_N] = cmp_diff[7];
      end
      ACT_INC: r.result = a + 8'd1;
      ACT_DEC: r.result = a - 8'd1;
      ACT_LOAD: r.result = b;
      ACT_ASL, ACT_ROL: begin
        r.result = {a[6:0], (beat.action == ACT_ROL) ? c : 1'b0};
        st[FLAG_C] = a[7];
      end
      ACT_LSR, ACT_ROR: begin
        r.result = {(beat.action == ACT_ROR) ? c : 1'b0, a[7:1]};
        st[FLAG_C] = a[0];
      end
      default: begin
        r.result_write = 1'b0;
        sets_nz = 1'b0;
        case (beat.action)
          ACT_CLC: st[FLAG_C] = 1'b0;
          ACT_SEC: st[FLAG_C] = 1'b1;
          ACT_CLI: st[FLAG_I] = 1'b0;
          ACT_SEI: st[FLAG_I] = 1'b1;
          ACT_CLV: st[FLAG_V] = 1'b0;
          ACT_CLD: st[FLAG_D] = 1'b0;
          ACT_SED: st[FLAG_D] = 1'b1;
          default: ;
        endcase
      end
    endcase
    if (sets_nz) begin
      st[FLAG_Z] = (r.result == 8'h00);
      st[FLAG_N] = r.result[7];
    end
    r.status_out = st;
    return r;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    logic [7:0] edges[4];
    edges = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("%0t: mismatch on %s: got %h, wanted %h", $time, field, got, want);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [4:0] act, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] st);
    alu_in_t beat;
    int gap;
    beat.action = act;
    beat.reg_value = a;
    beat.operand = b;
    beat.status_in = st;
    gap = sender_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    reg_value <= a;
    operand <= b;
    status_in <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    alu_results_due.push_back(nmos_alu_result(beat));
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (alu_results_due.size() == 0);
    @(negedge clk);
  endtask

  task automatic test_arith_edges();
    send_beat(ACT_ADC, 8'hFF, 8'h01, 8'h00);
    send_beat(ACT_ADC, 8'h7F, 8'h00, 8'h01);
    send_beat(ACT_ADC, 8'h99, 8'h01, 8'h08);
    send_beat(ACT_SBC, 8'h00, 8'h01, 8'h01);
    send_beat(ACT_SBC, 8'h80, 8'h01, 8'h01);
    send_beat(ACT_SBC, 8'h00, 8'h01, 8'h09);
  endtask

  task automatic test_logic_and_shifts();
    send_beat(ACT_AND, 8'hFF, 8'h00, 8'hFF);
    send_beat(ACT_ORA, 8'h80, 8'h01, 8'h30);
    send_beat(ACT_EOR, 8'hFF, 8'hFF, 8'h80);
    send_beat(ACT_BIT, 8'h3F, 8'hC0, 8'h00);
    send_beat(ACT_CMP, 8'h10, 8'h20, 8'hFF);
    send_beat(ACT_INC, 8'hFF, 8'h5A, 8'h00);
    send_beat(ACT_DEC, 8'h00, 8'hA5, 8'h02);
    send_beat(ACT_LOAD, 8'h55, 8'h80, 8'h02);
    send_beat(ACT_ASL, 8'h80, 8'h00, 8'h00);
    send_beat(ACT_LSR, 8'h01, 8'h00, 8'h80);
    send_beat(ACT_ROL, 8'h80, 8'h00, 8'h01);
    send_beat(ACT_ROR, 8'h01, 8'h00, 8'h01);
  endtask

  task automatic test_flag_actions();
    logic [4:0] acts[7];
    int k;
    acts = '{ACT_CLC, ACT_SEC, ACT_CLI, ACT_SEI, ACT_CLV, ACT_CLD, ACT_SED};
    for (k = 0; k < 7; k++) begin
      send_beat(acts[k], 8'h3C, 8'hC3, (k % 2 == 0) ? 8'hFF : 8'h00);
    end
  endtask

  task automatic test_unknown_actions();
    send_beat(5'd21, 8'hAA, 8'h55, 8'hFF);
    send_beat(5'd31, 8'h00, 8'hFF, 8'h00);
  endtask

  task automatic test_random_mix();
    int n;
    int roll;
    logic [4:0] act;
    logic [7:0] a;
    logic [7:0] b;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      if (n % 250 == 125) pause_until_drained();
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        act = 5'($urandom_range(21, 31));
      end else if (roll < 40) begin
        act = roll[0] ? ACT_ADC : ACT_SBC;
      end else begin
        act = 5'($urandom_range(0, 20));
      end
      if ((act == ACT_ADC || act == ACT_SBC) && $urandom_range(0, 2) == 0) begin
        a = random_bcd();
        b = random_bcd();
      end else begin
        a = random_byte();
        b = random_byte();
      end
      send_beat(act, a, b, random_byte());
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6))
        @(negedge clk);
      if (idle_len() > 0) begin
        out_stall <= 1'b1;
        repeat (idle_len() + 1) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    alu_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (alu_results_due.size() == 0) begin
        report_mismatch("beat with nothing due", result, 8'h00);
      end else begin
        want = alu_results_due.pop_front();
        if (result !== want.result) report_mismatch("result", result, want.result);
        if (result_write !== want.result_write) begin
          report_mismatch("result_write", {7'b0, result_write}, {7'b0, want.result_write});
        end
        if (status_out !== want.status_out) begin
          report_mismatch("status_out", status_out, want.status_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[byte_alu_with_bcd_flags_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ADC;
    reg_value = 8'h00;
    operand = 8'h00;
    status_in = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_arith_edges();
    test_logic_and_shifts();
    test_flag_actions();
    test_unknown_actions();
    test_random_mix();
    in_valid <= 1'b0;
    wait (alu_results_due.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[byte_alu_with_bcd_flags_top] OK");
    end else begin
      $display("[byte_alu_with_bcd_flags_top] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bafl_pkg.sv
rtl/bafl_alu.sv
rtl/byte_alu_with_bcd_flags_top.sv
tb/tb.sv
